// ===== rtl/ebv_pkg.sv =====
// shared types, constants and vint encoding functions for the ebml vint encoder
`timescale 1ns / 1ps

package ebv_pkg;

  localparam int unsigned CmdW       = 3;
  localparam int unsigned IdW        = 32;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned PlenW      = 31;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 4;
  localparam int unsigned MaxVintLen = 8;
  localparam int unsigned FifoDepthDef = 2;

  localparam logic [7:0] VintMarker  = 8'h80;
  localparam logic [7:0] UnknownSize = 8'hff;

  typedef enum logic [CmdW-1:0] {
    CMD_UVINT       = 3'd0,
    CMD_SVINT       = 3'd1,
    CMD_INT_ELEM    = 3'd2,
    CMD_ELEM_HDR    = 3'd3,
    CMD_UNKNOWN_HDR = 3'd4
  } cmd_e;

  // one run of big-endian bytes, taken from the low len bytes of data
  typedef struct packed {
    logic [ValueW-1:0] data;
    logic [LenW-1:0]   len;
  } seg_t;

  // a classified command: up to three runs, a run with len zero ends the list
  typedef struct packed {
    seg_t [2:0] seg;
  } desc_t;

  // single 0xff byte for a value that does not fit
  function automatic seg_t seg_ff();
    seg_t r;
    r.data = {{(ValueW-8){1'b0}}, UnknownSize};
    r.len  = LenW'(1);
    return r;
  endfunction

  // unsigned vint: smallest length with n below 2^(7L)-1, marker bit at 2^(7L)
  function automatic seg_t vint_u(input logic [ValueW-1:0] n);
    seg_t              r;
    logic [ValueW-1:0] lim;
    r = seg_ff();
    for (int l = MaxVintLen; l >= 1; l--) begin
      lim = {{(ValueW-1){1'b0}}, 1'b1} << (7 * l);
      if (n < lim - {{(ValueW-1){1'b0}}, 1'b1}) begin
        r.data = n | lim;
        r.len  = LenW'(l);
      end
    end
    return r;
  endfunction

  // signed vint: smallest length with |v| below 2^(7L-1), biased by 2^(7L-1)-1
  function automatic seg_t vint_s(input logic [ValueW-1:0] v);
    seg_t              r;
    logic [ValueW-1:0] half;
    logic [ValueW-1:0] sel;
    logic              found;
    r     = seg_ff();
    sel   = '0;
    found = 1'b0;
    for (int l = MaxVintLen; l >= 1; l--) begin
      half = {{(ValueW-1){1'b0}}, 1'b1} << (7 * l - 1);
      if ((!v[ValueW-1] && (v < half)) ||
          (v[ValueW-1] && (v > ({ValueW{1'b0}} - half)))) begin
        sel   = half;
        r.len = LenW'(l);
        found = 1'b1;
      end
    end
    if (found) begin
      r.data = (v + sel - {{(ValueW-1){1'b0}}, 1'b1}) | (sel << 1);
    end
    return r;
  endfunction

  // byte count of v with leading zero bytes stripped, at least one
  function automatic logic [LenW-1:0] int_bytes(input logic [ValueW-1:0] v);
    logic [LenW-1:0] nb;
    nb = LenW'(1);
    for (int k = 1; k < ValueW / ByteW; k++) begin
      if (v[ByteW*k +: ByteW] != '0) begin
        nb = LenW'(k + 1);
      end
    end
    return nb;
  endfunction

endpackage

// ===== rtl/ebv_intf.sv =====
// command and byte stream channel interfaces
`timescale 1ns / 1ps

interface ebv_cmd_if
  import ebv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [IdW-1:0]    element_id;
  logic [ValueW-1:0] value;
  logic [PlenW-1:0]  payload_length;

  modport source (output valid, command, element_id, value, payload_length, input ready);
  modport sink   (input valid, command, element_id, value, payload_length, output ready);
endinterface

interface ebv_byte_if
  import ebv_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== rtl/ebml_vint_element_encoder_top.sv =====
// top level of the ebml vint and element header encoder
// command path: front register, queue, back-end descriptor, output register
// throughput: one byte per cycle while byte_o is ready; a command has 1 to 14
//   output bytes, sent by the single-byte serializer in the back end
// a new command is taken every cycle while the descriptor queue has room
// reset (async, active low) empties the queue and clears all valid flags
`timescale 1ns / 1ps

module ebml_vint_element_encoder_top
  import ebv_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ebv_cmd_if.sink    cmd_i,
  ebv_byte_if.source byte_o
);

  // front register to queue
  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;

  // queue to back end
  logic  pop_valid;
  logic  pop;
  desc_t pop_desc;

  // classify each command into up to three byte runs (id, size, value)
  ebv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_desc_o  (push_desc),
    .push_ready_i (push_ready)
  );

  // decouples command intake from byte output so each side stalls alone
  ebv_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_desc_i  (push_desc),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_desc_o   (pop_desc),
    .pop_i        (pop)
  );

  // serialize runs most significant byte first, last marks the final byte
  ebv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_desc_i  (pop_desc),
    .pop_o       (pop),
    .byte_o      (byte_o)
  );

endmodule

// ===== rtl/ebv_front.sv =====
// front end: takes commands and classifies them into byte-run descriptors
`timescale 1ns / 1ps

module ebv_front
  import ebv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ebv_cmd_if.sink     cmd_i,
  output logic        push_valid_o,
  output desc_t       push_desc_o,
  input  logic        push_ready_i
);

  logic  valid_q;
  logic  valid_d;
  desc_t desc_q;
  desc_t desc_d;
  logic  keep;
  logic  take;
  seg_t  id_seg;
  seg_t  nb_seg;
  logic [LenW-1:0] nb;

  assign cmd_i.ready  = !valid_q || push_ready_i;
  assign take         = cmd_i.valid && cmd_i.ready;
  assign push_valid_o = valid_q;
  assign push_desc_o  = desc_q;

  always_comb begin
    id_seg      = vint_u({{(ValueW-IdW){1'b0}}, cmd_i.element_id});
    nb          = int_bytes(cmd_i.value);
    nb_seg.data = {{(ValueW-8){1'b0}}, VintMarker | {4'd0, nb}};
    nb_seg.len  = LenW'(1);
  end

  // unused command codes produce nothing and are dropped here
  always_comb begin
    desc_d = '0;
    keep   = 1'b1;
    unique case (cmd_e'(cmd_i.command))
      CMD_UVINT: begin
        desc_d.seg[0] = vint_u(cmd_i.value);
      end
      CMD_SVINT: begin
        desc_d.seg[0] = vint_s(cmd_i.value);
      end
      CMD_INT_ELEM: begin
        desc_d.seg[0]      = id_seg;
        desc_d.seg[1]      = nb_seg;
        desc_d.seg[2].data = cmd_i.value;
        desc_d.seg[2].len  = nb;
      end
      CMD_ELEM_HDR: begin
        desc_d.seg[0] = id_seg;
        desc_d.seg[1] = vint_u({{(ValueW-PlenW){1'b0}}, cmd_i.payload_length});
      end
      CMD_UNKNOWN_HDR: begin
        desc_d.seg[0] = id_seg;
        desc_d.seg[1] = seg_ff();
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = keep;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      desc_q <= desc_d;
    end
  end

endmodule

// ===== rtl/ebv_fifo.sv =====
// short descriptor queue between front and back
`timescale 1ns / 1ps

module ebv_fifo
  import ebv_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  desc_t push_desc_i,
  output logic  push_ready_o,
  output logic  pop_valid_o,
  output desc_t pop_desc_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

endmodule

// ===== rtl/ebv_back.sv =====
// back end: walks a descriptor one byte per cycle into the output register while byte_o is not stalled
`timescale 1ns / 1ps

module ebv_back
  import ebv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  desc_t      pop_desc_i,
  output logic       pop_o,
  ebv_byte_if.source byte_o
);

  desc_t           cur_q;
  logic            cur_valid_q, cur_valid_d;
  logic [1:0]      seg_q, seg_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic            out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic            out_last_q;

  logic             emit;
  logic             seg_end;
  logic             next_ok;
  logic [LenW-1:0]  next_len;
  logic             msg_end;
  logic             load;
  logic [2:0]       bidx;
  logic [ValueW-1:0] seg_data;
  logic [ByteW-1:0] cur_byte;

  assign byte_o.valid    = out_valid_q;
  assign byte_o.out_byte = out_byte_q;
  assign byte_o.last     = out_last_q;

  always_comb begin
    case (seg_q)
      2'd0:    next_len = cur_q.seg[1].len;
      2'd1:    next_len = cur_q.seg[2].len;
      default: next_len = '0;
    endcase
  end

  assign emit     = cur_valid_q && (!out_valid_q || byte_o.ready);
  assign seg_end  = (rem_q == LenW'(1));
  assign next_ok  = (next_len != '0);
  assign msg_end  = seg_end && !next_ok;
  assign load     = pop_valid_i && (!cur_valid_q || (emit && msg_end));
  assign pop_o    = load;
  assign seg_data = cur_q.seg[seg_q].data;
  assign bidx     = 3'(rem_q - LenW'(1));
  assign cur_byte = seg_data[{bidx, 3'b000} +: ByteW];

  always_comb begin
    cur_valid_d = cur_valid_q;
    seg_d       = seg_q;
    rem_d       = rem_q;
    if (emit) begin
      if (!seg_end) begin
        rem_d = rem_q - LenW'(1);
      end else if (next_ok) begin
        seg_d = seg_q + 2'd1;
        rem_d = next_len;
      end else begin
        cur_valid_d = 1'b0;
      end
    end
    if (load) begin
      cur_valid_d = 1'b1;
      seg_d       = 2'd0;
      rem_d       = pop_desc_i.seg[0].len;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (byte_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      seg_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      seg_q       <= seg_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= pop_desc_i;
    end
    if (emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= msg_end;
    end
  end

endmodule

// ===== rtl/ebv_checker.sv =====
// port-level checker for the encoder top, attached by bind
`timescale 1ns / 1ps

module ebv_checker
  import ebv_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_i,
  input logic             out_last_i
);

  logic [LenW-1:0] cnt_q;
  logic            seen_q;
  logic            out_xfer;

  assign out_xfer = out_valid_i && out_ready_i;

  // bytes already sent in the current message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      seen_q <= 1'b0;
    end else begin
      if (out_xfer) begin
        cnt_q <= out_last_i ? '0 : cnt_q + LenW'(1);
      end
      if (in_valid_i && in_ready_i) begin
        seen_q <= 1'b1;
      end
    end
  end

  a_reset_idle : assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled output changed");

  a_msg_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (cnt_q < LenW'(13)) || ((cnt_q == LenW'(13)) && out_last_i))
    else $error("message longer than fourteen bytes");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_q)
    else $error("output before any command");

endmodule

bind ebml_vint_element_encoder_top ebv_checker u_ebv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_byte_i  (byte_o.out_byte),
  .out_last_i  (byte_o.last)
);
